// ===== rtl/core/sed_pkg.sv =====
package sed_pkg;

    typedef enum logic [2:0] {
        PH_TEXT,
        PH_ESC,
        PH_HEX,
        PH_UOPEN,
        PH_UFOUR,
        PH_UBRACE,
        PH_DROP
    } phase_t;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_BAD_X         = 3'd1;
    localparam logic [2:0] ST_BAD_BRACE_HEX = 3'd2;
    localparam logic [2:0] ST_TOO_LONG      = 3'd3;
    localparam logic [2:0] ST_NO_DIGITS     = 3'd4;
    localparam logic [2:0] ST_UNTERMINATED  = 3'd5;
    localparam logic [2:0] ST_BAD_U4        = 3'd6;
    localparam logic [2:0] ST_NOT_SCALAR    = 3'd7;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam int QUEUE_DEPTH = 4;
    localparam int COUNT_W     = 17;

    typedef struct packed {
        logic [3:0][7:0]      bytes;
        logic [2:0]           nbytes;
        logic                 is_end;
        logic [2:0]           status;
        logic [COUNT_W-1:0]   count;
    } cmd_t;

endpackage

// ===== rtl/core/string_escape_decoder.sv =====
// Each result of a byte passes through the command queue and then the output register.
// Throughput: one source byte accepted per cycle and one result delivered per cycle while
//   out_ready is high; an escape expanding to several UTF-8 bytes is absorbed by a
//   4-entry command queue, so input stalls only once that queue fills.
// Reset: rst_n asynchronous, active low; clears escape state, error, count and queue.
module string_escape_decoder #(
    parameter int MAX_LITERAL = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        is_end,
    output logic [2:0]  status,
    output logic [16:0] decoded_count,
    output logic        run_last
);
    import sed_pkg::*;

    localparam int          CapInt   = (MAX_LITERAL < 131071) ? MAX_LITERAL : 131071;
    localparam logic [16:0] CountCap = 17'(CapInt);

    logic push, full, pop, head_valid;
    cmd_t push_cmd, head_cmd;

    sed_front #(
        .COUNT_CAP (CountCap)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .is_last  (is_last),
        .q_full   (full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    sed_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    sed_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .is_end        (is_end),
        .status        (status),
        .decoded_count (decoded_count),
        .run_last      (run_last)
    );

endmodule

// ===== rtl/core/sed_front.sv =====
module sed_front #(
    parameter logic [16:0] COUNT_CAP = 17'd65536
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          is_last,
    input  logic          q_full,
    output logic          push,
    output sed_pkg::cmd_t push_cmd
);
    import sed_pkg::*;

    phase_t          phase_reg, phase_next;
    logic [2:0]      digit_reg, digit_next;
    logic [23:0]     accum_reg, accum_next;
    logic [2:0]      err_reg, err_next;
    logic [16:0]     total_reg, total_next;

    logic            accept;
    logic            hex_ok;
    logic [3:0]      hex_val;
    logic [23:0]     cp_sel;
    logic            scalar_ok;
    logic [2:0]      enc_n;
    logic [3:0][7:0] enc_b;
    logic            fail;
    logic [2:0]      fail_code;
    logic [2:0]      ne;
    logic [3:0][7:0] eb;
    logic [17:0]     sum;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        priority if (in_byte >= 8'h30 && in_byte <= 8'h39)
            hex_val = in_byte[3:0];
        else if ((in_byte >= 8'h61 && in_byte <= 8'h66) || (in_byte >= 8'h41 && in_byte <= 8'h46))
            hex_val = 4'(in_byte[3:0] + 4'd9);
        else
            hex_ok = 1'b0;
    end

    assign cp_sel    = (phase_reg == PH_UFOUR) ? {accum_reg[19:0], hex_val} : accum_reg;
    assign scalar_ok = (cp_sel <= 24'h10FFFF) && !(cp_sel >= 24'h00D800 && cp_sel <= 24'h00DFFF);

    always_comb
    begin
        enc_b = '0;
        priority if (cp_sel < 24'h000080)
        begin
            enc_n    = 3'd1;
            enc_b[0] = cp_sel[7:0];
        end
        else if (cp_sel < 24'h000800)
        begin
            enc_n    = 3'd2;
            enc_b[0] = {3'b110, cp_sel[10:6]};
            enc_b[1] = {2'b10, cp_sel[5:0]};
        end
        else if (cp_sel < 24'h010000)
        begin
            enc_n    = 3'd3;
            enc_b[0] = {4'b1110, cp_sel[15:12]};
            enc_b[1] = {2'b10, cp_sel[11:6]};
            enc_b[2] = {2'b10, cp_sel[5:0]};
        end
        else
        begin
            enc_n    = 3'd4;
            enc_b[0] = {5'b11110, cp_sel[20:18]};
            enc_b[1] = {2'b10, cp_sel[17:12]};
            enc_b[2] = {2'b10, cp_sel[11:6]};
            enc_b[3] = {2'b10, cp_sel[5:0]};
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        digit_next = digit_reg;
        accum_next = accum_reg;
        err_next   = err_reg;
        fail       = 1'b0;
        fail_code  = ST_OK;
        ne         = 3'd0;
        eb         = '0;

        unique case (phase_reg)
            PH_TEXT:
            begin
                if (in_byte == CH_BSLASH && !is_last)
                    phase_next = PH_ESC;
                else
                begin
                    ne    = 3'd1;
                    eb[0] = in_byte;
                end
            end
            PH_ESC:
            begin
                phase_next = PH_TEXT;
                ne         = 3'd1;
                unique case (in_byte)
                    CH_N:    eb[0] = 8'h0A;
                    CH_R:    eb[0] = 8'h0D;
                    CH_T:    eb[0] = 8'h09;
                    CH_B:    eb[0] = 8'h08;
                    CH_F:    eb[0] = 8'h0C;
                    CH_ZERO: eb[0] = 8'h00;
                    CH_BSLASH, CH_DQUOTE, CH_SQUOTE, CH_DOLLAR, CH_BTICK:
                        eb[0] = in_byte;
                    CH_X:
                    begin
                        ne         = 3'd0;
                        phase_next = PH_HEX;
                        digit_next = 3'd0;
                        accum_next = '0;
                    end
                    CH_U:
                    begin
                        ne         = 3'd0;
                        phase_next = PH_UOPEN;
                        digit_next = 3'd0;
                        accum_next = '0;
                    end
                    default:
                    begin
                        ne    = 3'd2;
                        eb[0] = CH_BSLASH;
                        eb[1] = in_byte;
                    end
                endcase
            end
            PH_HEX:
            begin
                if (!hex_ok)
                begin
                    fail      = 1'b1;
                    fail_code = ST_BAD_X;
                end
                else
                begin
                    accum_next = {accum_reg[19:0], hex_val};
                    digit_next = 3'(digit_reg + 3'd1);
                    if (digit_next >= 3'd2)
                    begin
                        phase_next = PH_TEXT;
                        ne         = 3'd1;
                        eb[0]      = accum_next[7:0];
                    end
                end
            end
            PH_UOPEN:
            begin
                if (in_byte == CH_LBRACE)
                    phase_next = PH_UBRACE;
                else if (!hex_ok)
                begin
                    fail      = 1'b1;
                    fail_code = ST_BAD_U4;
                end
                else
                begin
                    accum_next = {20'd0, hex_val};
                    digit_next = 3'd1;
                    phase_next = PH_UFOUR;
                end
            end
            PH_UFOUR:
            begin
                if (!hex_ok)
                begin
                    fail      = 1'b1;
                    fail_code = ST_BAD_U4;
                end
                else
                begin
                    accum_next = cp_sel;
                    digit_next = 3'(digit_reg + 3'd1);
                    if (digit_next >= 3'd4)
                    begin
                        if (!scalar_ok)
                        begin
                            fail      = 1'b1;
                            fail_code = ST_NOT_SCALAR;
                        end
                        else
                        begin
                            ne         = enc_n;
                            eb         = enc_b;
                            phase_next = PH_TEXT;
                        end
                    end
                end
            end
            PH_UBRACE:
            begin
                if (in_byte == CH_RBRACE)
                begin
                    if (digit_reg == 3'd0)
                    begin
                        fail      = 1'b1;
                        fail_code = ST_NO_DIGITS;
                    end
                    else if (!scalar_ok)
                    begin
                        fail      = 1'b1;
                        fail_code = ST_NOT_SCALAR;
                    end
                    else
                    begin
                        ne         = enc_n;
                        eb         = enc_b;
                        phase_next = PH_TEXT;
                    end
                end
                else if (!hex_ok)
                begin
                    fail      = 1'b1;
                    fail_code = ST_BAD_BRACE_HEX;
                end
                else if (digit_reg >= 3'd6)
                begin
                    fail      = 1'b1;
                    fail_code = ST_TOO_LONG;
                end
                else
                begin
                    accum_next = {accum_reg[19:0], hex_val};
                    digit_next = 3'(digit_reg + 3'd1);
                end
            end
            default:
                phase_next = PH_DROP;
        endcase

        if (fail)
        begin
            if (err_next == ST_OK)
                err_next = fail_code;
            phase_next = PH_DROP;
        end

        if (is_last && err_next == ST_OK)
        begin
            unique case (phase_next)
                PH_HEX:    err_next = ST_BAD_X;
                PH_UOPEN:  err_next = ST_BAD_U4;
                PH_UFOUR:  err_next = ST_BAD_U4;
                PH_UBRACE: err_next = (digit_next == 3'd0) ? ST_NO_DIGITS : ST_UNTERMINATED;
                default:   err_next = ST_OK;
            endcase
        end
    end

    assign sum        = {1'b0, total_reg} + 18'(ne);
    assign total_next = (sum > {1'b0, COUNT_CAP}) ? COUNT_CAP : sum[16:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TEXT;
            digit_reg <= '0;
            accum_reg <= '0;
            err_reg   <= ST_OK;
            total_reg <= '0;
        end
        else if (accept)
        begin
            if (is_last)
            begin
                phase_reg <= PH_TEXT;
                digit_reg <= '0;
                accum_reg <= '0;
                err_reg   <= ST_OK;
                total_reg <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                digit_reg <= digit_next;
                accum_reg <= accum_next;
                err_reg   <= err_next;
                total_reg <= total_next;
            end
        end
    end

    assign push            = accept && (ne != 3'd0 || is_last);
    assign push_cmd.bytes  = eb;
    assign push_cmd.nbytes = ne;
    assign push_cmd.is_end = is_last;
    assign push_cmd.status = is_last ? err_next : ST_OK;
    assign push_cmd.count  = is_last ? total_next : '0;

endmodule

// ===== rtl/core/sed_queue.sv =====
module sed_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sed_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output sed_pkg::cmd_t head_cmd
);
    import sed_pkg::*;

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            mem_reg [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full       = (cnt_reg == CntW'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : PtrW'(wr_ptr_reg + 1'b1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : PtrW'(rd_ptr_reg + 1'b1);
        cnt_next = CntW'(cnt_reg + CntW'(do_push) - CntW'(do_pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== rtl/core/sed_back.sv =====
module sed_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  sed_pkg::cmd_t head_cmd,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          is_end,
    output logic [2:0]    status,
    output logic [16:0]   decoded_count,
    output logic          run_last
);
    import sed_pkg::*;

    logic [2:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg;
    logic        end_reg;
    logic [2:0]  status_reg;
    logic [16:0] count_reg;
    logic        run_last_reg;

    logic        load;
    logic        is_data;
    logic        last_res;

    assign load     = head_valid && (!out_valid_reg || out_ready);
    assign is_data  = idx_reg < head_cmd.nbytes;
    assign last_res = head_cmd.is_end ? (idx_reg == head_cmd.nbytes)
                                      : (idx_reg == 3'(head_cmd.nbytes - 3'd1));
    assign pop      = load && last_res;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = last_res ? 3'd0 : 3'(idx_reg + 3'd1);
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg     <= is_data ? head_cmd.bytes[idx_reg[1:0]] : 8'd0;
            end_reg      <= !is_data;
            status_reg   <= is_data ? ST_OK : head_cmd.status;
            count_reg    <= is_data ? '0 : head_cmd.count;
            run_last_reg <= last_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = byte_reg;
    assign is_end        = end_reg;
    assign status        = status_reg;
    assign decoded_count = count_reg;
    assign run_last      = run_last_reg;

endmodule

// ===== rtl/core/sed_checker.sv =====
module sed_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  in_byte,
    input logic        is_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_byte,
    input logic        is_end,
    input logic [2:0]  status,
    input logic [16:0] decoded_count,
    input logic        run_last
);
    import sed_pkg::*;

    // hold a stalled transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_end)
            && $stable(status) && $stable(decoded_count) && $stable(run_last))
        else $error("stalled output transaction changed");

    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_end |-> run_last && out_byte == 8'd0)
        else $error("end transaction malformed");

    a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_end |-> status == ST_OK && decoded_count == 17'd0)
        else $error("data transaction carries status or count");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_byte) && $stable(is_last))
        else $error("stalled input transaction changed");

endmodule

bind string_escape_decoder sed_checker u_sed_checker (.*);

// ===== tb/tb_top.sv =====
module tb_top;
    import sed_pkg::*;

    localparam int COUNT_CAP    = 65536;
    localparam int RANDOM_ITEMS = 245;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int PRINT_LIMIT  = 40;

    typedef struct packed {
        logic [7:0]  data;
        logic        fin;
        logic [2:0]  st;
        logic [16:0] cnt;
        logic        rl;
    } dec_res_t;

    typedef struct packed {
        logic [7:0] b;
        logic       lst;
        logic       typed;
        dec_res_t   fixed_res;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = 8'd0;
    logic        is_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        is_end;
    logic [2:0]  status;
    logic [16:0] decoded_count;
    logic        run_last;

    // decoder state mirrored by the predictor
    phase_t      esc_phase;
    logic [2:0]  dig_cnt;
    logic [23:0] cp_acc;
    logic [2:0]  err_code;
    logic [16:0] lit_count;

    dec_res_t    step_q[$];
    dec_res_t    expected_q[$];
    dec_res_t    head;
    stim_row_t   rows[$];
    logic [7:0]  lit_q[$];

    int          err_count = 0;
    int          results_checked = 0;
    int          items_sent = 0;
    int          literals = 0;
    int          cycle_cnt = 0;
    int          burst_left = 1;
    int          gap_left = 0;
    logic        gaps_on = 1'b1;
    logic        hold_req = 1'b0;

    string_escape_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .is_last       (is_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .is_end        (is_end),
        .status        (status),
        .decoded_count (decoded_count),
        .run_last      (run_last)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return 5'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66)
            return 5'(c - 8'h61 + 8'd10);
        if (c >= 8'h41 && c <= 8'h46)
            return 5'(c - 8'h41 + 8'd10);
        return 5'd16;
    endfunction

    task automatic reset_predictor();
        esc_phase = PH_TEXT;
        dig_cnt   = 3'd0;
        cp_acc    = 24'd0;
        err_code  = ST_OK;
        lit_count = 17'd0;
    endtask

    task automatic put_res(input logic [7:0] d, input logic f, input logic [2:0] s,
                           input logic [16:0] c);
        step_q.push_back({d, f, s, c, 1'b0});
    endtask

    task automatic emit_byte(input logic [7:0] d);
        put_res(d, 1'b0, ST_OK, 17'd0);
        if (lit_count < COUNT_CAP)
            lit_count = lit_count + 17'd1;
    endtask

    task automatic set_error(input logic [2:0] code);
        if (err_code == ST_OK)
            err_code = code;
        esc_phase = PH_DROP;
    endtask

    task automatic emit_code_point();
        logic [23:0] cp;
        cp = cp_acc;
        if (cp > 24'h10FFFF || (cp >= 24'hD800 && cp <= 24'hDFFF))
        begin
            set_error(ST_NOT_SCALAR);
        end
        else
        begin
            if (cp < 24'h80)
            begin
                emit_byte(cp[7:0]);
            end
            else if (cp < 24'h800)
            begin
                emit_byte({3'b110, cp[10:6]});
                emit_byte({2'b10, cp[5:0]});
            end
            else if (cp < 24'h10000)
            begin
                emit_byte({4'b1110, cp[15:12]});
                emit_byte({2'b10, cp[11:6]});
                emit_byte({2'b10, cp[5:0]});
            end
            else
            begin
                emit_byte({5'b11110, cp[20:18]});
                emit_byte({2'b10, cp[17:12]});
                emit_byte({2'b10, cp[11:6]});
                emit_byte({2'b10, cp[5:0]});
            end
            esc_phase = PH_TEXT;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic lst);
        logic [4:0] h;
        h = hex_val(b);
        step_q.delete();
        case (esc_phase)
            PH_TEXT:
                if (b == CH_BSLASH && !lst)
                    esc_phase = PH_ESC;
                else
                    emit_byte(b);
            PH_ESC:
            begin
                esc_phase = PH_TEXT;
                case (b)
                    CH_N:     emit_byte(8'h0A);
                    CH_R:     emit_byte(8'h0D);
                    CH_T:     emit_byte(8'h09);
                    CH_B:     emit_byte(8'h08);
                    CH_F:     emit_byte(8'h0C);
                    CH_ZERO:  emit_byte(8'h00);
                    CH_BSLASH, CH_DQUOTE, CH_SQUOTE, CH_DOLLAR, CH_BTICK:
                        emit_byte(b);
                    CH_X:
                    begin
                        esc_phase = PH_HEX;
                        dig_cnt   = 3'd0;
                        cp_acc    = 24'd0;
                    end
                    CH_U:
                    begin
                        esc_phase = PH_UOPEN;
                        dig_cnt   = 3'd0;
                        cp_acc    = 24'd0;
                    end
                    default:
                    begin
                        emit_byte(CH_BSLASH);
                        emit_byte(b);
                    end
                endcase
            end
            PH_HEX:
                if (h > 5'd15)
                begin
                    set_error(ST_BAD_X);
                end
                else
                begin
                    cp_acc  = {cp_acc[19:0], h[3:0]};
                    dig_cnt = dig_cnt + 3'd1;
                    if (dig_cnt >= 3'd2)
                    begin
                        esc_phase = PH_TEXT;
                        emit_byte(cp_acc[7:0]);
                    end
                end
            PH_UOPEN:
                if (b == CH_LBRACE)
                begin
                    esc_phase = PH_UBRACE;
                end
                else if (h > 5'd15)
                begin
                    set_error(ST_BAD_U4);
                end
                else
                begin
                    cp_acc    = {20'd0, h[3:0]};
                    dig_cnt   = 3'd1;
                    esc_phase = PH_UFOUR;
                end
            PH_UFOUR:
                if (h > 5'd15)
                begin
                    set_error(ST_BAD_U4);
                end
                else
                begin
                    cp_acc  = {cp_acc[19:0], h[3:0]};
                    dig_cnt = dig_cnt + 3'd1;
                    if (dig_cnt >= 3'd4)
                        emit_code_point();
                end
            PH_UBRACE:
                if (b == CH_RBRACE)
                begin
                    if (dig_cnt == 3'd0)
                        set_error(ST_NO_DIGITS);
                    else
                        emit_code_point();
                end
                else if (h > 5'd15)
                begin
                    set_error(ST_BAD_BRACE_HEX);
                end
                else if (dig_cnt >= 3'd6)
                begin
                    set_error(ST_TOO_LONG);
                end
                else
                begin
                    cp_acc  = {cp_acc[19:0], h[3:0]};
                    dig_cnt = dig_cnt + 3'd1;
                end
            default:
                esc_phase = PH_DROP;
        endcase

        if (lst)
        begin
            case (esc_phase)
                PH_HEX:             set_error(ST_BAD_X);
                PH_UOPEN, PH_UFOUR: set_error(ST_BAD_U4);
                PH_UBRACE:          set_error(dig_cnt == 3'd0 ? ST_NO_DIGITS : ST_UNTERMINATED);
                default:            ;
            endcase
            put_res(8'd0, 1'b1, err_code, lit_count);
            reset_predictor();
        end

        if (step_q.size() > 0)
            step_q[step_q.size() - 1].rl = 1'b1;
    endtask

    task automatic add_row(input logic [7:0] b, input logic lst);
        rows.push_back({b, lst, 1'b0, dec_res_t'(0)});
    endtask

    task automatic add_typed(input logic [7:0] b, input logic lst, input logic [7:0] d,
                             input logic f, input logic [2:0] s, input logic [16:0] c);
        rows.push_back({b, lst, 1'b1, d, f, s, c, 1'b1});
    endtask

    // hold the transaction until accepted, then predict its results
    task automatic send_item(input logic [7:0] b, input logic lst, input logic typed,
                             input dec_res_t fixed_res);
        if (gap_left > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_left) @(posedge clk);
            gap_left = 0;
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        is_last  <= lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        decode_byte(b, lst);
        if (typed)
            expected_q.push_back(fixed_res);
        else
            foreach (step_q[i])
                expected_q.push_back(step_q[i]);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (!gaps_on)
                gap_left = 0;
            else if ($urandom_range(0, 3) == 0)
                gap_left = $urandom_range(5, 20);
            else
                gap_left = $urandom_range(0, 3);
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + n;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (hex_val(c) <= 5'd15)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] simple_esc_char();
        case ($urandom_range(0, 10))
            0:       return CH_N;
            1:       return CH_R;
            2:       return CH_T;
            3:       return CH_B;
            4:       return CH_F;
            5:       return CH_ZERO;
            6:       return CH_BSLASH;
            7:       return CH_DQUOTE;
            8:       return CH_SQUOTE;
            9:       return CH_DOLLAR;
            default: return CH_BTICK;
        endcase
    endfunction

    function automatic logic [23:0] rand_code_point();
        case ($urandom_range(0, 9))
            0, 1:    return 24'($urandom_range(0, 24'h7F));
            2, 3:    return 24'($urandom_range(24'h80, 24'h7FF));
            4, 5:    return 24'($urandom_range(24'h800, 24'hFFFF));
            6, 7:    return 24'($urandom_range(24'h10000, 24'h10FFFF));
            8:       return 24'($urandom_range(24'hD800, 24'hDFFF));
            default: return 24'($urandom_range(24'h110000, 24'hFFFFFF));
        endcase
    endfunction

    task automatic add_hex(input logic [23:0] v, input int nd);
        for (int i = nd - 1; i >= 0; i--)
            lit_q.push_back(hex_char(v[i*4 +: 4]));
    endtask

    task automatic gen_literal();
        int          ntok;
        int          k;
        int          nd;
        int          cut;
        logic [23:0] v;
        lit_q.delete();
        ntok = $urandom_range(1, 6);
        repeat (ntok)
        begin
            k = $urandom_range(0, 19);
            if (k < 6)
            begin
                lit_q.push_back(8'($urandom_range(0, 255)));
            end
            else if (k < 9)
            begin
                lit_q.push_back(CH_BSLASH);
                lit_q.push_back(simple_esc_char());
            end
            else if (k < 10)
            begin
                lit_q.push_back(CH_BSLASH);
                lit_q.push_back(8'($urandom_range(0, 255)));
            end
            else if (k < 12)
            begin
                lit_q.push_back(CH_BSLASH);
                lit_q.push_back(CH_X);
                add_hex(24'($urandom_range(0, 255)), 2);
            end
            else if (k < 14)
            begin
                lit_q.push_back(CH_BSLASH);
                lit_q.push_back(CH_U);
                add_hex(24'($urandom_range(0, 16'hFFFF)), 4);
            end
            else if (k < 17)
            begin
                v  = rand_code_point();
                nd = 1;
                while (nd < 6 && (v >> (4 * nd)) != 0)
                    nd++;
                lit_q.push_back(CH_BSLASH);
                lit_q.push_back(CH_U);
                lit_q.push_back(CH_LBRACE);
                add_hex(v, $urandom_range(nd, 6));
                lit_q.push_back(CH_RBRACE);
            end
            else
            begin
                lit_q.push_back(CH_BSLASH);
                case ($urandom_range(0, 6))
                    0:
                    begin
                        lit_q.push_back(CH_X);
                        add_hex(24'($urandom_range(0, 15)), 1);
                        lit_q.push_back(non_hex_char());
                    end
                    1:
                    begin
                        lit_q.push_back(CH_X);
                        lit_q.push_back(non_hex_char());
                    end
                    2:
                    begin
                        lit_q.push_back(CH_U);
                        add_hex(24'($urandom_range(0, 255)), 2);
                        lit_q.push_back(non_hex_char());
                    end
                    3:
                    begin
                        lit_q.push_back(CH_U);
                        lit_q.push_back(CH_LBRACE);
                        add_hex(24'($urandom_range(0, 24'hFFFFFF)), 6);
                        add_hex(24'($urandom_range(0, 15)), 1);
                        lit_q.push_back(CH_RBRACE);
                    end
                    4:
                    begin
                        lit_q.push_back(CH_U);
                        lit_q.push_back(CH_LBRACE);
                        lit_q.push_back(CH_RBRACE);
                    end
                    5:
                    begin
                        lit_q.push_back(CH_U);
                        lit_q.push_back(CH_LBRACE);
                        add_hex(24'($urandom_range(0, 255)), 2);
                        lit_q.push_back(non_hex_char());
                    end
                    default:
                    begin
                        lit_q.push_back(CH_U);
                        lit_q.push_back(CH_LBRACE);
                        add_hex(24'($urandom_range(0, 4095)), 3);
                    end
                endcase
            end
        end
        // occasionally cut the literal short so it can end inside an escape
        if ($urandom_range(0, 9) == 0)
        begin
            cut = $urandom_range(1, 3);
            while (cut > 0 && lit_q.size() > 1)
            begin
                lit_q.delete(lit_q.size() - 1);
                cut--;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < PRINT_LIMIT)
            $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want,
                     results_checked);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch("result with nothing pending, out_byte", out_byte, 0);
            end
            else
            begin
                head = expected_q.pop_front();
                if (out_byte !== head.data)
                    report_mismatch("out_byte", out_byte, head.data);
                if (is_end !== head.fin)
                    report_mismatch("is_end", is_end, head.fin);
                if (status !== head.st)
                    report_mismatch("status", status, head.st);
                if (decoded_count !== head.cnt)
                    report_mismatch("decoded_count", decoded_count, head.cnt);
                if (run_last !== head.rl)
                    report_mismatch("run_last", run_last, head.rl);
            end
            results_checked++;
        end
    end

    // receiver back-pressure; a long hold-off on request
    initial
    begin
        int          hold_left;
        logic [31:0] rx_cycle;
        hold_left = 0;
        rx_cycle  = 0;
        forever
        begin
            @(posedge clk);
            rx_cycle = rx_cycle + 1;
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (rx_cycle[8:7])
                    2'd0:    out_ready <= 1'b1;
                    2'd1:    out_ready <= 1'($urandom_range(0, 1));
                    2'd2:    out_ready <= (rx_cycle[1:0] == 2'd0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results pending", cycle_cnt,
                     expected_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int         directed_n;
        reset_predictor();

        add_typed(8'h41, 1'b0, 8'h41, 1'b0, ST_OK, 17'd0);
        add_typed(8'hFF, 1'b0, 8'hFF, 1'b0, ST_OK, 17'd0);
        add_typed(8'h00, 1'b0, 8'h00, 1'b0, ST_OK, 17'd0);
        add_row(CH_BSLASH, 1'b1);
        add_row(CH_BSLASH, 1'b0);
        add_typed(CH_X, 1'b1, 8'h00, 1'b1, ST_BAD_X, 17'd0);
        add_row(CH_BSLASH, 1'b0);
        add_typed(CH_U, 1'b1, 8'h00, 1'b1, ST_BAD_U4, 17'd0);
        add_row(CH_BSLASH, 1'b0);
        add_row(CH_U, 1'b0);
        add_typed(8'h31, 1'b1, 8'h00, 1'b1, ST_BAD_U4, 17'd0);
        add_row(CH_BSLASH, 1'b0);
        add_row(CH_U, 1'b0);
        add_typed(CH_LBRACE, 1'b1, 8'h00, 1'b1, ST_NO_DIGITS, 17'd0);
        add_row(CH_BSLASH, 1'b0);
        add_row(CH_U, 1'b0);
        add_row(CH_LBRACE, 1'b0);
        add_typed(8'h31, 1'b1, 8'h00, 1'b1, ST_UNTERMINATED, 17'd0);
        add_row(CH_BSLASH, 1'b0);
        add_row(CH_U, 1'b0);
        add_row(8'h44, 1'b0);
        add_row(8'h38, 1'b0);
        add_row(8'h30, 1'b0);
        add_row(8'h30, 1'b0);
        add_typed(8'h7A, 1'b1, 8'h00, 1'b1, ST_NOT_SCALAR, 17'd0);
        directed_n = rows.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_item(rows[i].b, rows[i].lst, rows[i].typed, rows[i].fixed_res);
        literals = 7;

        hold_req = 1'b1;
        while (items_sent < directed_n + RANDOM_ITEMS)
        begin
            // second half runs without idle gaps
            if (items_sent >= directed_n + RANDOM_ITEMS / 2)
                gaps_on = 1'b0;
            gen_literal();
            foreach (lit_q[i])
                send_item(lit_q[i], i == lit_q.size() - 1, 1'b0, dec_res_t'(0));
            literals++;
        end
        in_valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Sent %0d bytes in %0d literals (escapes, UTF-8 forms, errors, truncation,",
                 items_sent, literals);
        $display("  long output stall); checked %0d results, %0d mismatches",
                 results_checked, err_count);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
